/* rtl/r16ex_pkg.sv */
// Shared types and constants for the 16-bit MOV/ADD/SUB execution block.
// Used by the register file, the ALU, the top level and the checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package r16ex_pkg;

    localparam int unsigned REG_W     = 16;
    localparam int unsigned IDX_W     = 4;
    localparam int unsigned FUNC_W    = 3;
    // AX..ES live in the memory; FLAG is held in a register of its own
    localparam int unsigned RF_DEPTH  = 13;

    localparam logic [IDX_W-1:0] IDX_DX   = 4'd3;
    localparam logic [IDX_W-1:0] IDX_FLAG = 4'd13;

    // flag bit positions
    localparam int unsigned F_CF = 0;
    localparam int unsigned F_PF = 2;
    localparam int unsigned F_AF = 4;
    localparam int unsigned F_ZF = 6;
    localparam int unsigned F_SF = 7;
    localparam int unsigned F_OF = 11;

    localparam logic [REG_W-1:0] ARITH_MASK = 16'h08D5;

    typedef enum logic [FUNC_W-1:0] {
        FN_MOV_IMM16 = 3'd0,
        FN_MOV_IMM8  = 3'd1,
        FN_MOV_REG   = 3'd2,
        FN_ADD_REG   = 3'd3,
        FN_ADD_IMM   = 3'd4,
        FN_ADC_REG   = 3'd5,
        FN_SUB_IMM   = 3'd6
    } t_func;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // one instruction as captured at the input transfer
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [IDX_W-1:0]  dest;
        logic [IDX_W-1:0]  src;
        logic              high_half;
        logic [REG_W-1:0]  imm;
    } t_item;

    // execution outcome handed from the ALU to the top level
    typedef struct packed {
        logic [REG_W-1:0] value;
        logic [REG_W-1:0] flags;
        logic             error;
        logic             rf_we;
    } t_exec;

endpackage

`default_nettype wire

/* rtl/r16ex_regfile.sv */
// General register memory (AX..ES): two synchronous read ports, one write port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on r16ex_pkg.
`timescale 1ns / 1ps
`default_nettype none

module r16ex_regfile (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_rd_en,
    input  wire logic [r16ex_pkg::IDX_W-1:0]    i_rd_addr_a,
    input  wire logic [r16ex_pkg::IDX_W-1:0]    i_rd_addr_b,
    output logic      [r16ex_pkg::REG_W-1:0]    o_rd_data_a,
    output logic      [r16ex_pkg::REG_W-1:0]    o_rd_data_b,
    input  wire logic                           i_wr_en,
    input  wire logic [r16ex_pkg::IDX_W-1:0]    i_wr_addr,
    input  wire logic [r16ex_pkg::REG_W-1:0]    i_wr_data
);

    logic [r16ex_pkg::REG_W-1:0] r_mem [r16ex_pkg::RF_DEPTH];
    logic [r16ex_pkg::RF_DEPTH-1:0] r_vld;
    logic [r16ex_pkg::REG_W-1:0] r_rd_a;
    logic [r16ex_pkg::REG_W-1:0] r_rd_b;
    logic r_va;
    logic r_vb;
    logic a_ok;
    logic b_ok;
    logic [r16ex_pkg::IDX_W-1:0] addr_a;
    logic [r16ex_pkg::IDX_W-1:0] addr_b;

    assign a_ok   = (i_rd_addr_a < r16ex_pkg::IDX_W'(r16ex_pkg::RF_DEPTH));
    assign b_ok   = (i_rd_addr_b < r16ex_pkg::IDX_W'(r16ex_pkg::RF_DEPTH));
    assign addr_a = a_ok ? i_rd_addr_a : '0;
    assign addr_b = b_ok ? i_rd_addr_b : '0;

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr < r16ex_pkg::IDX_W'(r16ex_pkg::RF_DEPTH))) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[addr_a];
            r_rd_b <= r_mem[addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_va  <= 1'b0;
            r_vb  <= 1'b0;
        end else begin
            if (i_wr_en && (i_wr_addr < r16ex_pkg::IDX_W'(r16ex_pkg::RF_DEPTH))) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_va <= a_ok && r_vld[addr_a];
                r_vb <= b_ok && r_vld[addr_b];
            end
        end
    end

    assign o_rd_data_a = r_va ? r_rd_a : '0;
    assign o_rd_data_b = r_vb ? r_rd_b : '0;

endmodule

`default_nettype wire

/* rtl/r16ex_alu.sv */
// Operand selection, 16-bit add/subtract, byte merge and flag generation.
// Purely combinational. Depends on r16ex_pkg.
`timescale 1ns / 1ps
`default_nettype none

module r16ex_alu (
    input  wire r16ex_pkg::t_item               i_item,
    input  wire logic [r16ex_pkg::REG_W-1:0]    i_rf_a,
    input  wire logic [r16ex_pkg::REG_W-1:0]    i_rf_b,
    input  wire logic [r16ex_pkg::REG_W-1:0]    i_flags,
    output r16ex_pkg::t_exec                    o_exec
);

    logic [r16ex_pkg::REG_W-1:0] op_a;
    logic [r16ex_pkg::REG_W-1:0] op_b;
    logic [r16ex_pkg::REG_W-1:0] res;
    logic [r16ex_pkg::REG_W-1:0] arith_flags;
    logic [r16ex_pkg::REG_W:0]   wide;
    logic uses_src;
    logic is_arith;
    logic is_sub;
    logic cin;
    logic carry;
    logic ovf;
    logic err;

    always_comb begin
        uses_src = (i_item.func == r16ex_pkg::FN_MOV_REG)
                || (i_item.func == r16ex_pkg::FN_ADD_REG)
                || (i_item.func == r16ex_pkg::FN_ADC_REG);

        op_a = (i_item.dest == r16ex_pkg::IDX_FLAG) ? i_flags : i_rf_a;
        if (uses_src) begin
            op_b = (i_item.src == r16ex_pkg::IDX_FLAG) ? i_flags : i_rf_b;
        end else begin
            op_b = i_item.imm;
        end

        err = (i_item.dest > r16ex_pkg::IDX_FLAG)
           || (uses_src && (i_item.src > r16ex_pkg::IDX_FLAG));

        is_arith = 1'b0;
        is_sub   = 1'b0;
        cin      = 1'b0;
        res      = op_a;
        case (i_item.func)
            r16ex_pkg::FN_MOV_IMM16: begin
                res = i_item.imm;
                err = err || (i_item.dest > r16ex_pkg::IDX_DX);
            end
            r16ex_pkg::FN_MOV_IMM8: begin
                res = i_item.high_half ? {i_item.imm[7:0], op_a[7:0]}
                                       : {op_a[15:8], i_item.imm[7:0]};
                err = err || (i_item.dest > r16ex_pkg::IDX_DX);
            end
            r16ex_pkg::FN_MOV_REG: begin
                res = op_b;
            end
            r16ex_pkg::FN_ADD_REG, r16ex_pkg::FN_ADD_IMM: begin
                is_arith = 1'b1;
            end
            r16ex_pkg::FN_ADC_REG: begin
                is_arith = 1'b1;
                cin      = i_flags[r16ex_pkg::F_CF];
            end
            r16ex_pkg::FN_SUB_IMM: begin
                is_arith = 1'b1;
                is_sub   = 1'b1;
            end
            default: begin
                err = 1'b1;
            end
        endcase

        // one shared adder: subtract as a + ~b + 1, borrow is the inverted carry
        wide  = {1'b0, op_a} + {1'b0, (is_sub ? ~op_b : op_b)}
              + {{r16ex_pkg::REG_W{1'b0}}, (is_sub | cin)};
        carry = is_sub ? ~wide[r16ex_pkg::REG_W] : wide[r16ex_pkg::REG_W];
        if (is_sub) begin
            ovf = (op_a[15] ^ op_b[15]) & (op_a[15] ^ wide[15]);
        end else begin
            ovf = ~(op_a[15] ^ op_b[15]) & (op_a[15] ^ wide[15]);
        end
        if (is_arith) begin
            res = wide[r16ex_pkg::REG_W-1:0];
        end

        arith_flags = i_flags & ~r16ex_pkg::ARITH_MASK;
        arith_flags[r16ex_pkg::F_CF] = carry;
        arith_flags[r16ex_pkg::F_PF] = ~^wide[7:0];
        arith_flags[r16ex_pkg::F_AF] = op_a[4] ^ op_b[4] ^ wide[4];
        arith_flags[r16ex_pkg::F_ZF] = (wide[r16ex_pkg::REG_W-1:0] == '0);
        arith_flags[r16ex_pkg::F_SF] = wide[15];
        arith_flags[r16ex_pkg::F_OF] = ovf;

        o_exec.error = err;
        o_exec.rf_we = ~err && (i_item.dest != r16ex_pkg::IDX_FLAG);
        o_exec.value = err ? '0 : res;
        if (err) begin
            o_exec.flags = i_flags;
        end else if (i_item.dest == r16ex_pkg::IDX_FLAG) begin
            // the stored result wins over the freshly computed flags
            o_exec.flags = res;
        end else if (is_arith) begin
            o_exec.flags = arith_flags;
        end else begin
            o_exec.flags = i_flags;
        end
    end

endmodule

`default_nettype wire

/* rtl/reg16_mov_add_sub_exec.sv */
// The operands are read from the register memory at the input transfer; the
// instruction then executes and writes back in the execute state and its result
// goes to the output register. No new instruction is taken until this one has executed.
// A finished result waits in the output register; the execute cycle stalls
// only while that register is still full and not taken.
// Reset (i_rst_n low, synchronous) zeroes all registers, FLAG and all control.
`timescale 1ns / 1ps
`default_nettype none

module reg16_mov_add_sub_exec (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // instruction channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [r16ex_pkg::FUNC_W-1:0]   i_func,
    input  wire logic [r16ex_pkg::IDX_W-1:0]    i_dest_reg,
    input  wire logic [r16ex_pkg::IDX_W-1:0]    i_src_reg,
    input  wire logic                           i_high_half,
    input  wire logic [r16ex_pkg::REG_W-1:0]    i_immediate,
    // result channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic      [r16ex_pkg::REG_W-1:0]    o_result_value,
    output logic      [r16ex_pkg::REG_W-1:0]    o_flags_out,
    output logic                                o_error
);

    r16ex_pkg::t_state r_state;
    r16ex_pkg::t_state n_state;

    r16ex_pkg::t_item  r_item;
    r16ex_pkg::t_exec  exec;

    logic [r16ex_pkg::REG_W-1:0] r_flags;
    logic [r16ex_pkg::REG_W-1:0] rf_a;
    logic [r16ex_pkg::REG_W-1:0] rf_b;

    logic                        r_out_valid;
    logic [r16ex_pkg::REG_W-1:0] r_out_value;
    logic [r16ex_pkg::REG_W-1:0] r_out_flags;
    logic                        r_out_error;

    logic in_xfer;
    logic exec_fire;

    // ---------------------------------------------------------------
    // Control: next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            r16ex_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_state = r16ex_pkg::ST_EXEC;
                end
            end
            r16ex_pkg::ST_EXEC: begin
                if (exec_fire) begin
                    n_state = r16ex_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = r16ex_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Control: outputs of the state machine
    // ---------------------------------------------------------------
    always_comb begin
        o_in_ready = 1'b0;
        exec_fire  = 1'b0;
        case (r_state)
            r16ex_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            r16ex_pkg::ST_EXEC: begin
                // execute only when the output register can take the result
                exec_fire = ~r_out_valid | i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assign in_xfer = i_in_valid & o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= r16ex_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the instruction for the execute cycle.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item.func      <= i_func;
            r_item.dest      <= i_dest_reg;
            r_item.src       <= i_src_reg;
            r_item.high_half <= i_high_half;
            r_item.imm       <= i_immediate;
        end
    end

    // ---------------------------------------------------------------
    // Register memory: read both operands at the transfer, write back
    // in the execute cycle. The next read can only happen after the
    // write has landed, so no forwarding is needed.
    // ---------------------------------------------------------------
    r16ex_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (in_xfer),
        .i_rd_addr_a (i_dest_reg),
        .i_rd_addr_b (i_src_reg),
        .o_rd_data_a (rf_a),
        .o_rd_data_b (rf_b),
        .i_wr_en     (exec_fire & exec.rf_we),
        .i_wr_addr   (r_item.dest),
        .i_wr_data   (exec.value)
    );

    r16ex_alu u_alu (
        .i_item  (r_item),
        .i_rf_a  (rf_a),
        .i_rf_b  (rf_b),
        .i_flags (r_flags),
        .o_exec  (exec)
    );

    // FLAG lives outside the memory since every instruction may need it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (exec_fire) begin
            r_flags <= exec.flags;
        end
    end

    // ---------------------------------------------------------------
    // Output register: load on execute, drop on transfer out.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_out_value <= exec.value;
            r_out_flags <= exec.flags;
            r_out_error <= exec.error;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_flags_out    = r_out_flags;
    assign o_error        = r_out_error;

endmodule

`default_nettype wire

/* rtl/r16ex_checker.sv */
// Port-level checker for reg16_mov_add_sub_exec, attached by bind.
// Depends on r16ex_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module r16ex_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire logic                           o_in_ready,
    input  wire logic                           o_out_valid,
    input  wire logic                           i_out_ready,
    input  wire logic [r16ex_pkg::REG_W-1:0]    o_result_value,
    input  wire logic [r16ex_pkg::REG_W-1:0]    o_flags_out,
    input  wire logic                           o_error
);

    // a waiting result holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_result_value) && $stable(o_flags_out)
            && $stable(o_error))
        else $error("result changed while stalled");

    // one instruction at a time: no transfer in the cycle after one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("accepted back-to-back instructions");

    // a refused instruction reports a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error |-> o_result_value == '0)
        else $error("refused instruction with nonzero value");

    // a fresh result appears only after an input transfer, once the instruction
    // has passed the execute state and then the output register
    a_rise_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("result without a preceding transfer");

endmodule

bind reg16_mov_add_sub_exec r16ex_checker u_r16ex_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_result_value (o_result_value),
    .o_flags_out    (o_flags_out),
    .o_error        (o_error)
);

`default_nettype wire
